### sv/ctt_pkg.sv
package ctt_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int OUT_W = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [3:0] KIND_LBRACKET = 4'd0;
   localparam logic [3:0] KIND_RBRACKET = 4'd1;
   localparam logic [3:0] KIND_COMMA = 4'd2;
   localparam logic [3:0] KIND_EQUAL = 4'd3;
   localparam logic [3:0] KIND_DOT = 4'd4;
   localparam logic [3:0] KIND_EOF = 4'd5;
   localparam logic [3:0] KIND_NUMBER = 4'd6;
   localparam logic [3:0] KIND_STRING = 4'd7;
   localparam logic [3:0] KIND_NULL = 4'd8;
   localparam logic [3:0] KIND_TRUE = 4'd9;
   localparam logic [3:0] KIND_FALSE = 4'd10;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_UTF8 = 2'd1;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd2;
   localparam logic [1:0] ERR_UNKNOWN = 2'd3;

   localparam logic [31:0] WORD_NULL = 32'h6E756C6C;
   localparam logic [31:0] WORD_TRUE = 32'h74727565;
   localparam logic [39:0] WORD_FALSE = 40'h66616C7365;

   typedef struct packed {
      logic [3:0]       token_kind;
      logic [1:0]       error_code;
      logic [OUT_W-1:0] token_start;
      logic [OUT_W-1:0] token_length;
      logic             last_of_run;
   } token_type;

   // results of one accepted byte, in order
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

endpackage

### sv/ctt_front.sv
module ctt_front #(
   parameter int OFFSET_BITS = ctt_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         text_byte,
   output ctt_pkg::push_type  push
);

   localparam int OW = ctt_pkg::OUT_W;
   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_NUMBER = 3'd1;
   localparam logic [2:0] MODE_WORD = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_DISCARD = 3'd4;

   localparam logic [7:0] CHR_NUL = 8'h00;
   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_SQUOTE = 8'h27;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;

   logic [2:0]             mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] origin_ff, origin_in;
   logic                   single_ff, single_in;
   logic                   bslash_ff, bslash_in;
   logic [1:0]             pend_ff, pend_in;
   logic [39:0]            prefix_ff, prefix_in;

   logic [OFFSET_BITS-1:0] pos_inc;
   logic [OFFSET_BITS-1:0] span;
   logic                   number_cont;
   logic                   word_cont;
   logic [7:0]             quote;

   logic                   idle_emit;
   logic [2:0]             idle_mode;
   ctt_pkg::token_type     idle_tok;

   ctt_pkg::token_type     res_a, res_b;
   logic [1:0]             res_n;

   assign pos_inc = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign span = pos_ff - origin_ff;
   assign quote = single_ff ? CHR_SQUOTE : CHR_DQUOTE;

   always_comb begin
      number_cont = 1'b0;
      case (text_byte) inside
         [8'h30:8'h39], 8'h2E, 8'h2B, 8'h2D, 8'h65, 8'h45: number_cont = 1'b1;
         default: number_cont = 1'b0;
      endcase
   end

   always_comb begin
      word_cont = 1'b0;
      case (text_byte) inside
         [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, 8'h2D: word_cont = 1'b1;
         default: word_cont = 1'b0;
      endcase
   end

   // fresh lex of the byte from idle; shared by idle mode and number or word ends
   always_comb begin
      idle_emit = 1'b1;
      idle_mode = MODE_IDLE;
      idle_tok.token_kind = ctt_pkg::KIND_LBRACKET;
      idle_tok.error_code = ctt_pkg::ERR_NONE;
      idle_tok.token_start = OW'(pos_ff);
      idle_tok.token_length = OW'(1);
      idle_tok.last_of_run = 1'b0;
      unique case (text_byte) inside
         8'h5B: idle_tok.token_kind = ctt_pkg::KIND_LBRACKET;
         8'h5D: idle_tok.token_kind = ctt_pkg::KIND_RBRACKET;
         8'h2C: idle_tok.token_kind = ctt_pkg::KIND_COMMA;
         8'h3D: idle_tok.token_kind = ctt_pkg::KIND_EQUAL;
         8'h2E: idle_tok.token_kind = ctt_pkg::KIND_DOT;
         8'h00: begin
            idle_tok.token_kind = ctt_pkg::KIND_EOF;
            idle_tok.token_length = '0;
         end
         [8'h30:8'h39], 8'h2B, 8'h2D: begin
            idle_emit = 1'b0;
            idle_mode = MODE_NUMBER;
         end
         8'h22, 8'h27: begin
            idle_emit = 1'b0;
            idle_mode = MODE_STRING;
         end
         [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: begin
            idle_emit = 1'b0;
            idle_mode = MODE_WORD;
         end
         default: begin
            idle_mode = MODE_DISCARD;
            idle_tok.token_kind = ctt_pkg::KIND_LBRACKET;
            idle_tok.error_code = ctt_pkg::ERR_UNKNOWN;
            idle_tok.token_length = '0;
         end
      endcase
   end

   always_comb begin
      logic run_idle;
      ctt_pkg::token_type err_tok;
      ctt_pkg::token_type end_tok;

      mode_in = mode_ff;
      origin_in = origin_ff;
      single_in = single_ff;
      bslash_in = bslash_ff;
      pend_in = pend_ff;
      prefix_in = prefix_ff;
      res_a = idle_tok;
      res_b = idle_tok;
      res_n = 2'd0;
      run_idle = 1'b0;

      err_tok.token_kind = ctt_pkg::KIND_LBRACKET;
      err_tok.error_code = ctt_pkg::ERR_UTF8;
      err_tok.token_start = OW'(pos_ff);
      err_tok.token_length = '0;
      err_tok.last_of_run = 1'b0;

      end_tok.token_kind = ctt_pkg::KIND_NUMBER;
      end_tok.error_code = ctt_pkg::ERR_NONE;
      end_tok.token_start = OW'(origin_ff);
      end_tok.token_length = OW'(span);
      end_tok.last_of_run = 1'b0;

      unique case (mode_ff)
         MODE_IDLE: run_idle = 1'b1;
         MODE_NUMBER: begin
            if (!number_cont) begin
               res_a = end_tok;
               res_n = 2'd1;
               run_idle = 1'b1;
            end
         end
         MODE_WORD: begin
            if (word_cont) begin
               prefix_in = {prefix_ff[31:0], text_byte};
            end else begin
               // keyword only when the whole identifier matches
               if (span == OFFSET_BITS'(4) && prefix_ff[31:0] == ctt_pkg::WORD_NULL) begin
                  end_tok.token_kind = ctt_pkg::KIND_NULL;
               end else if (span == OFFSET_BITS'(4) &&
                            prefix_ff[31:0] == ctt_pkg::WORD_TRUE) begin
                  end_tok.token_kind = ctt_pkg::KIND_TRUE;
               end else if (span == OFFSET_BITS'(5) && prefix_ff == ctt_pkg::WORD_FALSE) begin
                  end_tok.token_kind = ctt_pkg::KIND_FALSE;
               end else begin
                  end_tok.token_kind = ctt_pkg::KIND_STRING;
               end
               res_a = end_tok;
               res_n = 2'd1;
               run_idle = 1'b1;
            end
         end
         MODE_STRING: begin
            if (pend_ff != 2'd0) begin
               if (text_byte[7:6] == 2'b10) begin
                  pend_in = pend_ff - 2'd1;
                  bslash_in = 1'b0;
               end else begin
                  res_a = err_tok;
                  res_n = 2'd1;
                  mode_in = MODE_DISCARD;
               end
            end else if (text_byte == CHR_NUL) begin
               err_tok.error_code = ctt_pkg::ERR_UNTERMINATED;
               res_a = err_tok;
               res_n = 2'd1;
               mode_in = MODE_DISCARD;
            end else if (!text_byte[7]) begin
               if (text_byte == quote && !bslash_ff) begin
                  end_tok.token_kind = ctt_pkg::KIND_STRING;
                  res_a = end_tok;
                  res_n = 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  bslash_in = (text_byte == CHR_BACKSLASH);
               end
            end else begin
               bslash_in = 1'b0;
               case (text_byte) inside
                  [8'hC2:8'hDF]: pend_in = 2'd1;
                  [8'hE0:8'hEF]: pend_in = 2'd2;
                  [8'hF0:8'hF4]: pend_in = 2'd3;
                  default: begin
                     res_a = err_tok;
                     res_n = 2'd1;
                     mode_in = MODE_DISCARD;
                  end
               endcase
            end
         end
         default: mode_in = MODE_DISCARD;
      endcase

      if (run_idle) begin
         mode_in = idle_mode;
         if (idle_emit) begin
            if (res_n == 2'd0) begin
               res_a = idle_tok;
            end else begin
               res_b = idle_tok;
            end
            res_n = res_n + 2'd1;
         end
         unique case (idle_mode)
            MODE_NUMBER: origin_in = pos_ff;
            MODE_WORD: begin
               origin_in = pos_ff;
               prefix_in = {32'd0, text_byte};
            end
            MODE_STRING: begin
               origin_in = pos_inc;
               single_in = (text_byte == CHR_SQUOTE);
               bslash_in = 1'b0;
               pend_in = 2'd0;
            end
            default: ;
         endcase
      end

      if (text_byte == CHR_NUL) begin
         mode_in = MODE_IDLE;
         pos_in = '0;
         origin_in = '0;
         bslash_in = 1'b0;
         pend_in = 2'd0;
         prefix_in = '0;
      end else begin
         pos_in = pos_inc;
      end

      if (res_n == 2'd2) begin
         res_b.last_of_run = 1'b1;
      end else begin
         res_a.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff <= '0;
         origin_ff <= '0;
         single_ff <= 1'b0;
         bslash_ff <= 1'b0;
         pend_ff <= 2'd0;
         prefix_ff <= '0;
      end else if (take) begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         origin_ff <= origin_in;
         single_ff <= single_in;
         bslash_ff <= bslash_in;
         pend_ff <= pend_in;
         prefix_ff <= prefix_in;
      end
   end

   assign push.count = take ? res_n : 2'd0;
   assign push.first = res_a;
   assign push.second = res_b;

endmodule

### sv/ctt_queue.sv
module ctt_queue (
   input  logic               clock,
   input  logic               reset,
   input  ctt_pkg::push_type  push,
   input  logic               pop,
   output logic               full,
   output logic               nonempty,
   output ctt_pkg::token_type head
);

   localparam int DEPTH = ctt_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(DEPTH);

   ctt_pkg::token_type q_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic [PW-1:0] wr_next;

   assign wr_next = wr_ff + 1'b1;
   // room for two words must remain, a byte can yield two tokens
   assign full = (cnt_ff > (PW + 1)'(DEPTH - 2));
   assign nonempty = (cnt_ff != '0);
   assign head = q_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff + PW'(push.count);
      rd_in = rd_ff + PW'(pop);
      cnt_in = cnt_ff + (PW + 1)'(push.count) - (PW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### sv/ctt_back.sv
module ctt_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         nonempty,
   input  ctt_pkg::token_type           head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [3:0]                   rsp_token_kind,
   output logic [1:0]                   rsp_error_code,
   output logic [ctt_pkg::OUT_W-1:0]    rsp_token_start,
   output logic [ctt_pkg::OUT_W-1:0]    rsp_token_length,
   output logic                         rsp_last_of_run
);

   logic               valid_ff, valid_in;
   ctt_pkg::token_type word_ff;

   assign pop = nonempty && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         word_ff <= head;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_token_kind = word_ff.token_kind;
   assign rsp_error_code = word_ff.error_code;
   assign rsp_token_start = word_ff.token_start;
   assign rsp_token_length = word_ff.token_length;
   assign rsp_last_of_run = word_ff.last_of_run;

endmodule

### sv/config_text_tokenizer_core.sv
// channel   | ports                                   | direction
// req       | req_valid, req_stall, req_text_byte     | byte in
// rsp       | rsp_valid, rsp_stall, rsp_token_kind,   | token out
//           | rsp_error_code, rsp_token_start,        |
//           | rsp_token_length, rsp_last_of_run       |
//
// One byte per cycle is taken while req_stall is low; the lexer state updates in that cycle.
// A byte yields zero, one or two tokens; the output register sends one token
// per cycle while rsp_stall is low, so a byte's two tokens leave one after the other.
// A byte's first token passes through the token queue and the output register to rsp.
// req_stall rises when the 4-entry token queue has fewer than two free slots.
// Synchronous reset clears lexer state, queue pointers and rsp_valid.
module config_text_tokenizer_core #(
   parameter int OFFSET_BITS = ctt_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_text_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [3:0]                   rsp_token_kind,
   output logic [1:0]                   rsp_error_code,
   output logic [ctt_pkg::OUT_W-1:0]    rsp_token_start,
   output logic [ctt_pkg::OUT_W-1:0]    rsp_token_length,
   output logic                         rsp_last_of_run
);

   logic               take;
   logic               full;
   logic               nonempty;
   logic               pop;
   ctt_pkg::push_type  push;
   ctt_pkg::token_type head;

   assign req_stall = full;
   assign take = req_valid && !full;

   ctt_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .take(take),
      .text_byte(req_text_byte),
      .push(push)
   );

   ctt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop(pop),
      .full(full),
      .nonempty(nonempty),
      .head(head)
   );

   ctt_back u_back (
      .clock(clock),
      .reset(reset),
      .nonempty(nonempty),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind),
      .rsp_error_code(rsp_error_code),
      .rsp_token_start(rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

### sv/ctt_checker.sv
module ctt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [3:0]                rsp_token_kind,
   input logic [1:0]                rsp_error_code,
   input logic [ctt_pkg::OUT_W-1:0] rsp_token_length,
   input logic                      rsp_last_of_run
);

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
         $stable(rsp_error_code) && $stable(rsp_token_length) &&
         $stable(rsp_last_of_run))
      else $error("stalled token word changed");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ctt_pkg::ERR_NONE |->
         rsp_token_kind == ctt_pkg::KIND_LBRACKET && rsp_token_length == '0 &&
         rsp_last_of_run)
      else $error("error word with kind, length or not last");

   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ctt_pkg::ERR_NONE &&
         rsp_token_kind == ctt_pkg::KIND_EOF |-> rsp_token_length == '0 && rsp_last_of_run)
      else $error("end token with length or not last");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= ctt_pkg::KIND_FALSE)
      else $error("token kind out of range");

endmodule

bind config_text_tokenizer_core ctt_checker u_checker (.*);
